// ===== rtl/functional_graph_walk_length_assert.svh =====
// Assertion macros for the walk-length RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef FUNCTIONAL_GRAPH_WALK_LENGTH_ASSERT_SVH
`define FUNCTIONAL_GRAPH_WALK_LENGTH_ASSERT_SVH

`ifndef SYNTHESIS
`define FGWL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fgwl assertion failed");
`define FGWL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fgwl assertion failed");
`else
`define FGWL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FGWL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/fgwl_pkg.sv =====
// Types and constants for the functional graph walk-length block.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package fgwl_pkg;

    localparam int MAX_NODES = 1024;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = 11;
    localparam int EPOCH_W   = 8;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(1024);
    localparam logic [CNT_W-1:0] MAX_NODES_C    = CNT_W'(MAX_NODES);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/fgwl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; instantiated for the successor table and visited map.
`timescale 1ns / 1ps
`default_nettype none

module fgwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/functional_graph_walk_length.sv =====
// Top level of the functional graph walk-length block.
// Depends on fgwl_pkg, fgwl_ram and functional_graph_walk_length_assert.svh.
//
// Usage:
//   Request channel: start/busy. A request is taken at an edge with start high
//   and busy low. Kind load writes one successor entry and gives no result.
//   Kind query walks the successor table from node_index.
//   Result channel: o_result_valid strobes for one cycle with o_hop_count and
//   o_bad_successor. The receiver cannot stall; every result must be taken.
//   Configuration: i_cfg_valid/o_cfg_ready write node_count; ready is always
//   high and writes are expected only while idle.
// Timing:
//   A query with a start at or beyond node_count answers in the cycle after it
//   is taken. Otherwise the walk takes one successor-table read per cycle, and
//   the result is registered once a visited node or a bad successor is reached.
//   The walk rate is set by the single read port of the two memories.
//   Visited entries are tagged with an 8-bit epoch, so no per-query clear is
//   needed. After reset, and after every 255th walked query, a clearing pass
//   sweeps all 1024 entries of the visited map; busy is high throughout it.
`timescale 1ns / 1ps
`default_nettype none
`include "functional_graph_walk_length_assert.svh"

module functional_graph_walk_length (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_kind,
    input  wire logic [fgwl_pkg::IDX_W-1:0]  i_node_index,
    input  wire logic [fgwl_pkg::CNT_W-1:0]  i_successor,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [fgwl_pkg::CNT_W-1:0]  i_cfg_data,
    output logic                             o_result_valid,
    output logic      [fgwl_pkg::CNT_W-1:0]  o_hop_count,
    output logic                             o_bad_successor
);

    import fgwl_pkg::*;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_cur, n_cur;
    logic [CNT_W-1:0]     r_hops, n_hops;
    logic                 r_fwd, n_fwd;
    logic [EPOCH_W-1:0]   r_epoch, n_epoch;
    logic [IDX_W-1:0]     r_clr_cnt, n_clr_cnt;
    logic [CNT_W-1:0]     r_node_count;
    logic                 r_out_valid, n_out_valid;
    logic [CNT_W-1:0]     r_out_hops, n_out_hops;
    logic                 r_out_bad, n_out_bad;

    logic [CNT_W-1:0]     w_limit;
    logic                 w_take;
    logic                 w_bad_start;
    logic [CNT_W-1:0]     w_succ;
    logic [CNT_W-1:0]     w_succ_m1;
    logic [IDX_W-1:0]     w_next;
    logic [EPOCH_W-1:0]   w_vis_tag;
    logic                 w_visited;
    logic                 w_succ_bad;

    logic                 w_succ_we;
    logic [IDX_W-1:0]     w_raddr;
    logic                 w_vis_we;
    logic [IDX_W-1:0]     w_vis_waddr;
    logic [EPOCH_W-1:0]   w_vis_wdata;

    assign w_limit     = (r_node_count > MAX_NODES_C) ? MAX_NODES_C : r_node_count;
    assign w_take      = start && !busy;
    assign w_bad_start = {1'b0, i_node_index} >= w_limit;
    assign w_succ_m1   = w_succ - CNT_W'(1);
    assign w_next      = w_succ_m1[IDX_W-1:0];
    assign w_visited   = (w_vis_tag == r_epoch) || r_fwd;
    assign w_succ_bad  = (w_succ == '0) || (w_succ > w_limit);

    fgwl_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_NODES)
    ) u_succ_ram (
        .i_clk   (i_clk),
        .i_we    (w_succ_we),
        .i_waddr (i_node_index),
        .i_wdata (i_successor),
        .i_raddr (w_raddr),
        .o_rdata (w_succ)
    );

    fgwl_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (MAX_NODES)
    ) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (w_vis_we),
        .i_waddr (w_vis_waddr),
        .i_wdata (w_vis_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_vis_tag)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_take && (i_kind == KIND_QUERY) && !w_bad_start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_visited || w_succ_bad) begin
                    n_state = (r_epoch == '1) ? ST_CLEAR : ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // outputs and datapath
    always_comb begin
        busy        = (r_state != ST_IDLE);
        o_cfg_ready = 1'b1;
        w_succ_we   = 1'b0;
        w_raddr     = i_node_index;
        w_vis_we    = 1'b0;
        w_vis_waddr = r_cur;
        w_vis_wdata = r_epoch;
        n_cur       = r_cur;
        n_hops      = r_hops;
        n_fwd       = 1'b0;
        n_epoch     = r_epoch;
        n_clr_cnt   = r_clr_cnt;
        n_out_valid = 1'b0;
        n_out_hops  = r_out_hops;
        n_out_bad   = r_out_bad;
        unique case (r_state)
            ST_CLEAR: begin
                w_vis_we    = 1'b1;
                w_vis_waddr = r_clr_cnt;
                w_vis_wdata = '0;
                n_clr_cnt   = r_clr_cnt + IDX_W'(1);
                n_epoch     = EPOCH_W'(1);
            end
            ST_IDLE: begin
                if (w_take && (i_kind == KIND_LOAD)) begin
                    w_succ_we = 1'b1;
                end
                if (w_take && (i_kind == KIND_QUERY)) begin
                    n_cur  = i_node_index;
                    n_hops = '0;
                    if (w_bad_start) begin
                        n_out_valid = 1'b1;
                        n_out_hops  = '0;
                        n_out_bad   = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                w_raddr = w_next;
                if (w_visited) begin
                    n_out_valid = 1'b1;
                    n_out_hops  = r_hops;
                    n_out_bad   = 1'b0;
                    n_epoch     = r_epoch + EPOCH_W'(1);
                    n_clr_cnt   = '0;
                end else begin
                    w_vis_we = 1'b1;
                    if (w_succ_bad) begin
                        n_out_valid = 1'b1;
                        n_out_hops  = r_hops;
                        n_out_bad   = 1'b1;
                        n_epoch     = r_epoch + EPOCH_W'(1);
                        n_clr_cnt   = '0;
                    end else begin
                        n_cur  = w_next;
                        n_hops = r_hops + CNT_W'(1);
                        n_fwd  = (w_next == r_cur);
                    end
                end
            end
            default: begin
                n_clr_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_cnt    <= '0;
            r_epoch      <= '0;
            r_fwd        <= 1'b0;
            r_node_count <= NODE_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_epoch     <= n_epoch;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_hops     <= n_hops;
        r_out_hops <= n_out_hops;
        r_out_bad  <= n_out_bad;
    end

    assign o_result_valid  = r_out_valid;
    assign o_hop_count     = r_out_hops;
    assign o_bad_successor = r_out_bad;

    `FGWL_ASSERT_IMP(a_hops_bounded, i_clk, i_rst_n, r_state == ST_WALK, r_hops <= w_limit)
    `FGWL_ASSERT_IMP(a_epoch_live, i_clk, i_rst_n, r_state != ST_CLEAR, r_epoch != '0)
    `FGWL_ASSERT_IMP(a_result_source, i_clk, i_rst_n, o_result_valid, $past(r_state == ST_WALK) || $past(start && !busy && i_kind == KIND_QUERY))
    `FGWL_ASSERT_NXT(a_load_no_result, i_clk, i_rst_n, start && !busy && i_kind == KIND_LOAD, !o_result_valid && !busy)

endmodule

`default_nettype wire
